// ===== hdl/tkr_pkg.sv =====
// ----------------------------------------------------------------------------
// tkr_pkg
// Shared types, constants and the ranking compare for the top-k ranker.
// ----------------------------------------------------------------------------
package tkr_pkg;

    localparam int SCORE_W      = 32;
    localparam int MATCH_W      = 8;
    localparam int DOC_W        = 32;
    localparam int KEEP_W       = 5;
    localparam int DEF_MAX_KEEP = 16;
    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

    typedef enum logic
    {
        ST_IDLE,
        ST_EMIT
    } tkr_state_t;

    typedef struct packed
    {
        logic insert;
        logic flush;
        logic pop;
    } tkr_cmd_t;

    typedef struct packed
    {
        logic flush_empty;
        logic last_pop;
    } tkr_status_t;

    // true when candidate a ranks strictly before candidate b
    function automatic logic ranks_before(
        input logic [SCORE_W-1:0] sa,
        input logic [MATCH_W-1:0] ma,
        input logic [DOC_W-1:0]   da,
        input logic [SCORE_W-1:0] sb,
        input logic [MATCH_W-1:0] mb,
        input logic [DOC_W-1:0]   db
    );
        logic r;
        if (sa != sb)
        begin
            r = (sa > sb);
        end
        else if (ma != mb)
        begin
            r = (ma > mb);
        end
        else
        begin
            r = (da < db);
        end
        return r;
    endfunction

endpackage

// ===== hdl/tkr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkr_ctrl
// Controller: accepts candidates while idle, sequences the ranked output beats.
// ----------------------------------------------------------------------------
module tkr_ctrl
    import tkr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        final_candidate,
    input  logic        out_stall,
    input  tkr_status_t status,
    output logic        in_stall,
    output logic        out_valid,
    output tkr_cmd_t    cmd
);

    tkr_state_t state_reg;
    tkr_state_t state_next;
    logic       in_take;
    logic       out_take;

    assign in_take  = in_valid && (state_reg == ST_IDLE);
    assign out_take = (state_reg == ST_EMIT) && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && final_candidate && !status.flush_empty)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_take && status.last_pop)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        cmd.insert = 1'b0;
        cmd.flush  = 1'b0;
        cmd.pop    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.insert = in_valid;
                cmd.flush  = in_valid && final_candidate;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.pop   = out_take;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/tkr_datapath.sv =====
// ----------------------------------------------------------------------------
// tkr_datapath
// Ranked list of kept entries with parallel compare-and-shift insertion and a
// shift-out path for the ranked output beats.
// ----------------------------------------------------------------------------
module tkr_datapath
    import tkr_pkg::*;
#(
    parameter int MAX_KEEP = DEF_MAX_KEEP
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tkr_cmd_t           cmd,
    input  logic [KEEP_W-1:0]  cfg_wr_data,
    input  logic               cfg_wr_en,
    input  logic [SCORE_W-1:0] score,
    input  logic [MATCH_W-1:0] term_hits,
    input  logic [DOC_W-1:0]   doc_id,
    output logic [SCORE_W-1:0] ranked_score,
    output logic [MATCH_W-1:0] ranked_matches,
    output logic [DOC_W-1:0]   ranked_document,
    output logic               last_ranked,
    output tkr_status_t        status
);

    localparam int CNT_W = $clog2(MAX_KEEP + 1);
    localparam int CMP_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEEP);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [KEEP_W-1:0]  keep_reg;
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   total_next;
    logic [CNT_W-1:0]   remaining_reg;
    logic [CNT_W-1:0]   remaining_next;
    logic [CNT_W-1:0]   keep_eff;
    logic [CNT_W-1:0]   total_eff;
    logic [CNT_W-1:0]   total_new;

    logic [SCORE_W-1:0] score_reg [MAX_KEEP];
    logic [MATCH_W-1:0] match_reg [MAX_KEEP];
    logic [DOC_W-1:0]   doc_reg   [MAX_KEEP];
    logic [MAX_KEEP-1:0] take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg <= KEEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            keep_reg <= cfg_wr_data;
        end
    end

    assign keep_eff  = (CMP_W'(keep_reg) > CMP_W'(CNT_MAX)) ? CNT_MAX
                                                           : CNT_W'(keep_reg);
    assign total_eff = (total_reg > keep_eff) ? keep_eff : total_reg;
    assign total_new = (total_eff < keep_eff) ? total_eff + CNT_ONE : total_eff;

    always_comb
    begin
        total_next     = total_reg;
        remaining_next = remaining_reg;
        if (cmd.flush)
        begin
            total_next     = '0;
            remaining_next = total_new;
        end
        else if (cmd.insert && (keep_eff != '0))
        begin
            total_next = total_new;
        end
        else if (cmd.pop)
        begin
            remaining_next = remaining_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            total_reg     <= total_next;
            remaining_reg <= remaining_next;
        end
    end

    for (genvar i = 0; i < MAX_KEEP; i++)
    begin : g_lane
        logic [SCORE_W-1:0] s_next;
        logic [MATCH_W-1:0] m_next;
        logic [DOC_W-1:0]   d_next;
        logic               prev_take;
        logic               in_keep;

        assign take[i] = (CNT_W'(i) >= total_eff) ||
                         ranks_before(score, term_hits, doc_id,
                                      score_reg[i], match_reg[i], doc_reg[i]);
        assign in_keep = (CNT_W'(i) < keep_eff);

        if (i == 0)
        begin : g_head
            assign prev_take = 1'b0;
        end
        else
        begin : g_body
            assign prev_take = take[i-1];
        end

        always_comb
        begin
            s_next = score_reg[i];
            m_next = match_reg[i];
            d_next = doc_reg[i];
            priority if (cmd.insert && in_keep && prev_take)
            begin
                if (i > 0)
                begin
                    s_next = score_reg[(i > 0) ? i - 1 : 0];
                    m_next = match_reg[(i > 0) ? i - 1 : 0];
                    d_next = doc_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (cmd.insert && in_keep && take[i])
            begin
                s_next = score;
                m_next = term_hits;
                d_next = doc_id;
            end
            else if (cmd.pop && (i < MAX_KEEP - 1))
            begin
                s_next = score_reg[(i < MAX_KEEP - 1) ? i + 1 : i];
                m_next = match_reg[(i < MAX_KEEP - 1) ? i + 1 : i];
                d_next = doc_reg[(i < MAX_KEEP - 1) ? i + 1 : i];
            end
        end

        always_ff @(posedge clk)
        begin
            score_reg[i] <= s_next;
            match_reg[i] <= m_next;
            doc_reg[i]   <= d_next;
        end
    end

    assign ranked_score       = score_reg[0];
    assign ranked_matches     = match_reg[0];
    assign ranked_document    = doc_reg[0];
    assign last_ranked        = (remaining_reg == CNT_ONE);
    assign status.flush_empty = (total_new == '0);
    assign status.last_pop    = (remaining_reg == CNT_ONE);

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_MAX)
        else $error("kept total exceeds capacity");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> remaining_reg != '0)
        else $error("output beat with no entry left");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> total_reg == '0)
        else $error("list not emptied after final candidate");

endmodule

// ===== hdl/top_k_result_ranker.sv =====
// ----------------------------------------------------------------------------
// top_k_result_ranker
// Streaming top-k selection of scored candidates, emitted best first.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one candidate per beat: score
// (Q16.16), term_hits, doc_id and final_candidate. The list is
// kept ranked by score, then matched terms, then the smaller document id.
// An ordinary candidate is taken while idle; a new one may follow in the
// next cycle. A final candidate is ranked first, then the kept entries go
// out on the output channel (out_valid/out_stall), best first, one beat per
// cycle while not stalled, last_ranked on the final beat. The first beat
// appears the cycle after the final candidate is taken. in_stall stays
// high while the list drains, and a stall holds the head entry and its
// payload unchanged. cfg_wr_en/cfg_wr_data write keep_count; the user
// must write it only while idle, which the block does not enforce.
// Values above MAX_KEEP act as MAX_KEEP, zero reports nothing. Reset
// empties the list and sets keep_count to 16.
// ----------------------------------------------------------------------------
module top_k_result_ranker
    import tkr_pkg::*;
#(
    parameter int MAX_KEEP = DEF_MAX_KEEP
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [KEEP_W-1:0]  cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [SCORE_W-1:0] score,
    input  logic [MATCH_W-1:0] term_hits,
    input  logic [DOC_W-1:0]   doc_id,
    input  logic               final_candidate,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [SCORE_W-1:0] ranked_score,
    output logic [MATCH_W-1:0] ranked_matches,
    output logic [DOC_W-1:0]   ranked_document,
    output logic               last_ranked
);

    tkr_cmd_t    cmd;
    tkr_status_t status;

    tkr_ctrl u_ctrl
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .final_candidate (final_candidate),
        .out_stall       (out_stall),
        .status          (status),
        .in_stall        (in_stall),
        .out_valid       (out_valid),
        .cmd             (cmd)
    );

    tkr_datapath #(
        .MAX_KEEP (MAX_KEEP)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_wr_data     (cfg_wr_data),
        .cfg_wr_en       (cfg_wr_en),
        .score           (score),
        .term_hits       (term_hits),
        .doc_id          (doc_id),
        .ranked_score    (ranked_score),
        .ranked_matches  (ranked_matches),
        .ranked_document (ranked_document),
        .last_ranked     (last_ranked),
        .status          (status)
    );

endmodule
